// File: design/bdbs_pkg.sv
package bdbs_pkg;

   localparam int BANK_BITS   = 5;
   localparam int LOCAL_WIDTH = 19;
   localparam logic [8:0] OAM_BYTES = 9'd160;

   // bus map boundaries
   localparam logic [15:0] ADDR_ROM_BASE       = 16'h0000;
   localparam logic [15:0] ADDR_BANK_SEL_BASE  = 16'h2000;
   localparam logic [15:0] ADDR_BANKED_BASE    = 16'h4000;
   localparam logic [15:0] ADDR_MODE_SEL_BASE  = 16'h6000;
   localparam logic [15:0] ADDR_VIDEO_BASE     = 16'h8000;
   localparam logic [15:0] ADDR_CART_RAM_BASE  = 16'hA000;
   localparam logic [15:0] ADDR_WORK_RAM_BASE  = 16'hC000;
   localparam logic [15:0] ADDR_ECHO_BASE      = 16'hE000;
   localparam logic [15:0] ADDR_OAM_BASE       = 16'hFE00;
   localparam logic [15:0] ADDR_OAM_END        = 16'hFEA0;
   localparam logic [15:0] ADDR_JOYPAD         = 16'hFF00;
   localparam logic [15:0] ADDR_IO_FIRST       = 16'hFF01;
   localparam logic [15:0] ADDR_SOUND_BASE     = 16'hFF10;
   localparam logic [15:0] ADDR_SOUND_LAST     = 16'hFF3F;
   localparam logic [15:0] ADDR_LCD_BASE       = 16'hFF40;
   localparam logic [15:0] ADDR_DMA_REG        = 16'hFF46;
   localparam logic [15:0] ADDR_LCD_END        = 16'hFF4C;

   localparam logic [7:0] CART_SWITCH_LO = 8'd1;
   localparam logic [7:0] CART_SWITCH_HI = 8'd3;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_COPY  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      TGT_NONE     = 3'd0,
      TGT_ROM      = 3'd1,
      TGT_VIDEO    = 3'd2,
      TGT_CART_RAM = 3'd3,
      TGT_WORK_RAM = 3'd4
   } target_type;

   typedef struct packed {
      target_type             target;
      logic [LOCAL_WIDTH-1:0] local_addr;
      logic                   answer_ff;
      logic                   bad_access;
   } route_type;

   typedef struct packed {
      kind_type               kind;
      target_type             target;
      logic [LOCAL_WIDTH-1:0] local_addr;
      logic [7:0]             data_out;
      logic [7:0]             oam_offset;
      logic                   answer_ff;
      logic                   bad_access;
   } result_type;

   typedef struct packed {
      logic [BANK_BITS-1:0] rom_bank;
      logic                 copy_active;
      logic [15:0]          copy_address;
   } state_type;

endpackage

// File: design/bdbs_decode.sv
module bdbs_decode import bdbs_pkg::*; (
   input  logic [15:0]          addr,
   input  logic [BANK_BITS-1:0] rom_bank,
   output route_type            route
);

   always_comb begin
      route = '0;
      case (addr) inside
         [ADDR_ROM_BASE : ADDR_BANKED_BASE - 16'd1]: begin
            route.target     = TGT_ROM;
            route.local_addr = LOCAL_WIDTH'(addr);
         end
         [ADDR_BANKED_BASE : ADDR_VIDEO_BASE - 16'd1]: begin
            // offset inside the window is below 0x4000, so bank and offset just abut
            route.target     = TGT_ROM;
            route.local_addr = LOCAL_WIDTH'({rom_bank, addr[13:0]});
         end
         [ADDR_VIDEO_BASE : ADDR_CART_RAM_BASE - 16'd1]: begin
            route.target     = TGT_VIDEO;
            route.local_addr = LOCAL_WIDTH'(addr);
         end
         [ADDR_CART_RAM_BASE : ADDR_WORK_RAM_BASE - 16'd1]: begin
            route.target     = TGT_CART_RAM;
            route.local_addr = LOCAL_WIDTH'(16'(addr - ADDR_CART_RAM_BASE));
         end
         [ADDR_WORK_RAM_BASE : ADDR_ECHO_BASE - 16'd1]: begin
            route.target     = TGT_WORK_RAM;
            route.local_addr = LOCAL_WIDTH'(16'(addr - ADDR_WORK_RAM_BASE));
         end
         [ADDR_ECHO_BASE : ADDR_OAM_BASE - 16'd1]: begin
            route.target     = TGT_WORK_RAM;
            route.local_addr = LOCAL_WIDTH'(16'(addr - ADDR_ECHO_BASE));
         end
         [ADDR_OAM_BASE : ADDR_OAM_END - 16'd1],
         ADDR_JOYPAD,
         [ADDR_LCD_BASE : ADDR_LCD_END - 16'd1]: begin
            route.target     = TGT_VIDEO;
            route.local_addr = LOCAL_WIDTH'(addr);
         end
         [ADDR_SOUND_BASE : ADDR_SOUND_LAST]: begin
            route.answer_ff = 1'b1;
         end
         default: begin
            // unconnected IO and unmapped space
            route.answer_ff  = 1'b1;
            route.bad_access = 1'b1;
         end
      endcase
   end

endmodule

// File: design/bdbs_route.sv
module bdbs_route import bdbs_pkg::*; (
   input  op_type      op,
   input  logic [15:0] addr,
   input  logic [7:0]  wdata,
   input  logic [7:0]  cart_type,
   input  state_type   state,
   output result_type  result,
   output state_type   state_next
);

   logic [15:0]          eff_addr;
   logic [15:0]          dec_addr;
   route_type            dec;
   logic                 switchable;
   logic                 bank_sel_hit;
   logic                 rom_write_ok;
   logic [BANK_BITS-1:0] new_bank;
   logic [8:0]           off_next;

   // CPU accesses are steered onto the OAM byte being copied
   assign eff_addr = (state.copy_active && (op == OP_READ || op == OP_WRITE)) ?
                     16'(ADDR_OAM_BASE + {8'h00, state.copy_address[7:0]}) : addr;
   assign dec_addr = (op == OP_TICK) ? state.copy_address : eff_addr;

   bdbs_decode u_decode (
      .addr     (dec_addr),
      .rom_bank (state.rom_bank),
      .route    (dec)
   );

   assign switchable   = cart_type inside {[CART_SWITCH_LO : CART_SWITCH_HI]};
   assign bank_sel_hit = switchable && eff_addr >= ADDR_BANK_SEL_BASE &&
                         eff_addr < ADDR_BANKED_BASE;
   assign rom_write_ok = eff_addr < ADDR_BANK_SEL_BASE || bank_sel_hit ||
                         (switchable && eff_addr >= ADDR_MODE_SEL_BASE);
   assign new_bank     = wdata[BANK_BITS-1:0];
   assign off_next     = {1'b0, state.copy_address[7:0]} + 9'd1;

   always_comb begin
      result     = '0;
      state_next = state;
      case (op)
         OP_READ: begin
            result.kind       = KIND_READ;
            result.target     = dec.target;
            result.local_addr = dec.local_addr;
            result.answer_ff  = dec.answer_ff;
            result.bad_access = dec.bad_access;
         end
         OP_WRITE: begin
            if (eff_addr < ADDR_VIDEO_BASE) begin
               if (bank_sel_hit) begin
                  state_next.rom_bank = (new_bank == '0) ? BANK_BITS'(1) : new_bank;
               end
               result.bad_access = !rom_write_ok;
            end else if (eff_addr >= ADDR_IO_FIRST && eff_addr < ADDR_LCD_BASE) begin
               // sound writes are dropped quietly, the rest of this IO is flagged
               result.bad_access = !(eff_addr inside {[ADDR_SOUND_BASE : ADDR_SOUND_LAST]});
            end else if (eff_addr == ADDR_DMA_REG) begin
               state_next.copy_active  = 1'b1;
               state_next.copy_address = {wdata, 8'h00};
            end else if (dec.target == TGT_NONE) begin
               result.bad_access = 1'b1;
            end else begin
               result.kind       = KIND_WRITE;
               result.target     = dec.target;
               result.local_addr = dec.local_addr;
               result.data_out   = wdata;
            end
         end
         OP_TICK: begin
            if (state.copy_active) begin
               result.kind             = KIND_COPY;
               result.target           = dec.target;
               result.local_addr       = dec.local_addr;
               result.answer_ff        = dec.answer_ff;
               result.bad_access       = dec.bad_access;
               result.oam_offset       = state.copy_address[7:0];
               state_next.copy_address = state.copy_address + 16'd1;
               if (off_next >= OAM_BYTES) begin
                  state_next.copy_active = 1'b0;
               end
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

// File: design/bus_decoder_bank_switch_oam_dma_unit.sv
// Path: a transaction is captured in the input register, then decoded into the result
// register when that register is free; rsp is driven straight from the result register.
// Throughput: one transaction per cycle; the result register stalls only on rsp_tready.
// Reset (synchronous): ROM bank 1, OAM copy idle, cartridge type 0, both stages empty.
module bus_decoder_bank_switch_oam_dma_unit import bdbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,   // cartridge_type
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,     // [15:0] address, [23:16] write_data
   input  logic [1:0]  req_tuser,     // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,     // [2:0] target, [21:3] local_address,
                                      // [29:22] data_out, [37:30] oam_offset,
                                      // [38] answer_ff, [39] bad_access
   output logic [1:0]  rsp_tuser      // [1:0] kind
);

   logic                 in_valid_ff;
   logic [1:0]           in_op_ff;
   logic [15:0]          in_addr_ff;
   logic [7:0]           in_data_ff;
   logic [7:0]           cart_type_ff;
   logic [BANK_BITS-1:0] rom_bank_ff;
   logic                 copy_active_ff;
   logic [15:0]          copy_address_ff;
   logic                 rsp_valid_ff;
   result_type           rsp_ff;

   logic                 in_valid_in;
   logic                 rsp_valid_in;
   logic                 advance;
   state_type            state;
   state_type            state_next;
   result_type           result;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign state = '{rom_bank: rom_bank_ff, copy_active: copy_active_ff,
                    copy_address: copy_address_ff};

   bdbs_route u_route (
      .op         (op_type'(in_op_ff)),
      .addr       (in_addr_ff),
      .wdata      (in_data_ff),
      .cart_type  (cart_type_ff),
      .state      (state),
      .result     (result),
      .state_next (state_next)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         cart_type_ff    <= '0;
         rom_bank_ff     <= BANK_BITS'(1);
         copy_active_ff  <= 1'b0;
         copy_address_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cart_type_ff <= csr_wr_data;
         end
         if (advance) begin
            rom_bank_ff     <= state_next.rom_bank;
            copy_active_ff  <= state_next.copy_active;
            copy_address_ff <= state_next.copy_address;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= req_tuser;
         in_addr_ff <= req_tdata[15:0];
         in_data_ff <= req_tdata[23:16];
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {rsp_ff.bad_access, rsp_ff.answer_ff, rsp_ff.oam_offset,
                        rsp_ff.data_out, rsp_ff.local_addr, rsp_ff.target};

   a_bank_nonzero: assert property (@(posedge clock) disable iff (reset)
      rom_bank_ff != '0)
      else $error("ROM bank register holds zero");

   a_copy_offset_range: assert property (@(posedge clock) disable iff (reset)
      copy_active_ff |-> ({1'b0, copy_address_ff[7:0]} < OAM_BYTES))
      else $error("OAM copy running past its last byte");

   a_copy_needs_active: assert property (@(posedge clock) disable iff (reset)
      advance && result.kind == KIND_COPY |-> copy_active_ff)
      else $error("copy command issued with no copy running");

   a_write_routed: assert property (@(posedge clock) disable iff (reset)
      advance && result.kind == KIND_WRITE |-> !result.answer_ff && result.target != TGT_NONE)
      else $error("device write without a device");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("decoded transaction lost before the result register");

endmodule

// File: bench/bus_decoder_bank_switch_oam_dma_unit_tb.sv
module bus_decoder_bank_switch_oam_dma_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bdbs_pkg::*;

   // operation code that the block must ignore
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS = 188;
   localparam int STALL_LIMIT = 3000;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] addr;
      logic [7:0]  data;
   } bus_access_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = 24'h0;
   logic [1:0]  req_tuser = 2'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   bus_access_type pending_accesses[$];
   result_type     expected_routes[$];

   // predictor state
   logic [7:0]           cart_kind = 8'd0;
   logic [BANK_BITS-1:0] bank_sel = BANK_BITS'(1);
   logic                 copy_busy = 1'b0;
   logic [15:0]          copy_ptr = 16'h0;

   // copy bytes still to be ticked, as seen by the stimulus side
   int gen_copy_left = 0;

   int mismatches = 0;
   int result_no = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   bus_decoder_bank_switch_oam_dma_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   function automatic route_type route_of(logic [15:0] a);
      route_type r;
      r = '0;
      if (a < ADDR_BANKED_BASE) begin
         r.target = TGT_ROM;
         r.local_addr = LOCAL_WIDTH'(a);
      end else if (a < ADDR_VIDEO_BASE) begin
         r.target = TGT_ROM;
         r.local_addr = {bank_sel, a[13:0]};
      end else if (a < ADDR_CART_RAM_BASE) begin
         r.target = TGT_VIDEO;
         r.local_addr = LOCAL_WIDTH'(a);
      end else if (a < ADDR_WORK_RAM_BASE) begin
         r.target = TGT_CART_RAM;
         r.local_addr = LOCAL_WIDTH'(a - ADDR_CART_RAM_BASE);
      end else if (a < ADDR_ECHO_BASE) begin
         r.target = TGT_WORK_RAM;
         r.local_addr = LOCAL_WIDTH'(a - ADDR_WORK_RAM_BASE);
      end else if (a < ADDR_OAM_BASE) begin
         r.target = TGT_WORK_RAM;
         r.local_addr = LOCAL_WIDTH'(a - ADDR_ECHO_BASE);
      end else if (a < ADDR_OAM_END) begin
         r.target = TGT_VIDEO;
         r.local_addr = LOCAL_WIDTH'(a);
      end else if (a >= ADDR_JOYPAD && a < ADDR_LCD_END) begin
         if (a == ADDR_JOYPAD || a >= ADDR_LCD_BASE) begin
            r.target = TGT_VIDEO;
            r.local_addr = LOCAL_WIDTH'(a);
         end else if (a >= ADDR_SOUND_BASE && a <= ADDR_SOUND_LAST) begin
            r.answer_ff = 1'b1;
         end else begin
            r.answer_ff = 1'b1;
            r.bad_access = 1'b1;
         end
      end else begin
         r.answer_ff = 1'b1;
         r.bad_access = 1'b1;
      end
      return r;
   endfunction

   // routes one bus access and advances bank and copy state
   function automatic result_type route_access(bus_access_type acc);
      result_type res;
      route_type  rt;
      logic [15:0] a;
      logic [7:0]  off;
      logic        switchable;
      res = '0;
      a = acc.addr;
      switchable = cart_kind >= CART_SWITCH_LO && cart_kind <= CART_SWITCH_HI;
      // CPU traffic is steered onto the OAM byte being copied
      if (copy_busy && (acc.op == OP_READ || acc.op == OP_WRITE))
         a = ADDR_OAM_BASE + {8'h00, copy_ptr[7:0]};
      if (acc.op == OP_READ) begin
         rt = route_of(a);
         res.kind = KIND_READ;
         res.target = rt.target;
         res.local_addr = rt.local_addr;
         res.answer_ff = rt.answer_ff;
         res.bad_access = rt.bad_access;
      end else if (acc.op == OP_WRITE) begin
         if (a < ADDR_VIDEO_BASE) begin
            if (a >= ADDR_BANK_SEL_BASE) begin
               if (switchable && a < ADDR_BANKED_BASE)
                  bank_sel = (acc.data[BANK_BITS-1:0] == '0) ? BANK_BITS'(1)
                                                              : acc.data[BANK_BITS-1:0];
               else if (!(switchable && a >= ADDR_MODE_SEL_BASE))
                  res.bad_access = 1'b1;
            end
         end else if (a >= ADDR_IO_FIRST && a < ADDR_LCD_BASE) begin
            res.bad_access = !(a >= ADDR_SOUND_BASE && a <= ADDR_SOUND_LAST);
         end else if (a == ADDR_DMA_REG) begin
            copy_busy = 1'b1;
            copy_ptr = {acc.data, 8'h00};
         end else begin
            rt = route_of(a);
            if (rt.target == TGT_NONE) begin
               res.bad_access = 1'b1;
            end else begin
               res.kind = KIND_WRITE;
               res.target = rt.target;
               res.local_addr = rt.local_addr;
               res.data_out = acc.data;
            end
         end
      end else if (acc.op == OP_TICK && copy_busy) begin
         off = copy_ptr[7:0];
         rt = route_of(copy_ptr);
         res.kind = KIND_COPY;
         res.target = rt.target;
         res.local_addr = rt.local_addr;
         res.oam_offset = off;
         res.answer_ff = rt.answer_ff;
         res.bad_access = rt.bad_access;
         copy_ptr = copy_ptr + 16'd1;
         if ({1'b0, off} + 9'd1 >= OAM_BYTES)
            copy_busy = 1'b0;
      end
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatches < MAX_PRINTED)
         $display("mismatch at result %0d: %s", result_no, msg);
      mismatches++;
   endtask

   task automatic check_result(result_type want);
      if (rsp_tuser !== want.kind)
         report_mismatch($sformatf("kind %0h, want %0h", rsp_tuser, want.kind));
      if (rsp_tdata[2:0] !== want.target)
         report_mismatch($sformatf("target %0h, want %0h", rsp_tdata[2:0], want.target));
      if (rsp_tdata[21:3] !== want.local_addr)
         report_mismatch($sformatf("local address %0h, want %0h",
                                   rsp_tdata[21:3], want.local_addr));
      if (rsp_tdata[29:22] !== want.data_out)
         report_mismatch($sformatf("data out %0h, want %0h", rsp_tdata[29:22], want.data_out));
      if (rsp_tdata[37:30] !== want.oam_offset)
         report_mismatch($sformatf("oam offset %0h, want %0h",
                                   rsp_tdata[37:30], want.oam_offset));
      if (rsp_tdata[38] !== want.answer_ff)
         report_mismatch($sformatf("answer_ff %0b, want %0b", rsp_tdata[38], want.answer_ff));
      if (rsp_tdata[39] !== want.bad_access)
         report_mismatch($sformatf("bad_access %0b, want %0b", rsp_tdata[39], want.bad_access));
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            bus_access_type acc;
            acc = pending_accesses.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {acc.data, acc.addr};
            req_tuser <= acc.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= $urandom_range(99) >= recv_stall_pct;
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            bus_access_type acc;
            acc.op = req_tuser;
            acc.addr = req_tdata[15:0];
            acc.data = req_tdata[23:16];
            expected_routes.push_back(route_access(acc));
         end
         if (rsp_tvalid && rsp_tready) begin
            result_no++;
            if (expected_routes.size() == 0)
               report_mismatch("result with no transaction outstanding");
            else
               check_result(expected_routes.pop_front());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL bus_decoder_bank_switch_oam_dma_unit");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic add_access(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
      bus_access_type acc;
      acc.op = op;
      acc.addr = addr;
      acc.data = data;
      if (op == OP_WRITE && addr == ADDR_DMA_REG && gen_copy_left == 0)
         gen_copy_left = OAM_BYTES;
      else if (op == OP_TICK && gen_copy_left > 0)
         gen_copy_left--;
      pending_accesses.push_back(acc);
   endtask

   function automatic logic [15:0] random_address();
      case ($urandom_range(9))
         0: return 16'($urandom_range(16'hFFFF));
         1: return 16'($urandom_range(16'h3FFF));
         2: return 16'($urandom_range(16'h3FFF, 16'h2000));
         3: return 16'($urandom_range(16'h7FFF, 16'h4000));
         4: return 16'($urandom_range(16'hBFFF, 16'h8000));
         5: return 16'($urandom_range(16'hFDFF, 16'hC000));
         6: return 16'($urandom_range(16'hFEFF, 16'hFE00));
         7: return 16'($urandom_range(16'hFF4F, 16'hFF00));
         8: return 16'($urandom_range(16'hFFFF, 16'hFF00));
         default: return 16'($urandom_range(16'h7FFF, 16'h6000));
      endcase
   endfunction

   // bank values that collapse to zero show up often
   function automatic logic [7:0] random_byte();
      logic [7:0] corner[4] = '{8'h00, 8'h20, 8'hE0, 8'hFF};
      if ($urandom_range(7) == 0)
         return corner[$urandom_range(3)];
      return 8'($urandom_range(255));
   endfunction

   task automatic add_random_access();
      int roll;
      roll = $urandom_range(99);
      if (gen_copy_left > 0) begin
         if (roll < 70)
            add_access(OP_TICK, random_address(), random_byte());
         else if (roll < 82)
            add_access(OP_READ, random_address(), random_byte());
         else if (roll < 94)
            add_access(OP_WRITE, random_address(), random_byte());
         else
            add_access(OP_SPARE, random_address(), random_byte());
      end else if (roll < 5) begin
         add_access(OP_WRITE, ADDR_DMA_REG, random_byte());
      end else if (roll < 42) begin
         add_access(OP_READ, random_address(), random_byte());
      end else if (roll < 80) begin
         add_access(OP_WRITE, random_address(), random_byte());
      end else if (roll < 95) begin
         add_access(OP_TICK, random_address(), random_byte());
      end else begin
         add_access(OP_SPARE, random_address(), random_byte());
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_accesses.size() != 0 || req_tvalid || expected_routes.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_cart_type(logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cart_kind = value;
   endtask

   initial begin
      logic [7:0] cart_settings[RANDOM_PHASES] = '{8'd0, 8'd255, 8'd2, 8'd3, 8'd4, 8'd1};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_cart_type(8'd1);
      add_access(OP_READ,  16'h0000, 8'h00);
      add_access(OP_READ,  16'h4000, 8'h00);
      add_access(OP_WRITE, 16'h2000, 8'h00);   // bank 0 maps to 1
      add_access(OP_WRITE, 16'h3FFF, 8'hFF);
      add_access(OP_READ,  16'h7FFF, 8'h00);
      add_access(OP_WRITE, 16'h1FFF, 8'h5A);
      add_access(OP_WRITE, 16'h6000, 8'hA5);   // mode select
      add_access(OP_WRITE, 16'h4000, 8'h11);
      add_access(OP_READ,  16'h9FFF, 8'h00);
      add_access(OP_WRITE, 16'hA000, 8'hFF);
      add_access(OP_READ,  16'hE000, 8'h00);   // echo
      add_access(OP_READ,  16'hFDFF, 8'h00);
      add_access(OP_READ,  16'hFEA0, 8'h00);
      add_access(OP_READ,  16'hFF00, 8'h00);
      add_access(OP_READ,  16'hFF01, 8'h00);
      add_access(OP_READ,  16'hFF10, 8'h00);
      add_access(OP_WRITE, 16'hFF3F, 8'h77);
      add_access(OP_READ,  16'hFF4B, 8'h00);
      add_access(OP_READ,  16'hFFFF, 8'h00);
      add_access(OP_WRITE, 16'hFF4C, 8'h01);
      add_access(OP_TICK,  16'h0000, 8'h00);   // no copy running
      add_access(OP_SPARE, 16'hFFFF, 8'hFF);
      add_access(OP_WRITE, ADDR_DMA_REG, 8'hFF);
      add_access(OP_READ,  16'h1234, 8'h00);   // steered to OAM
      add_access(OP_WRITE, ADDR_DMA_REG, 8'h00);  // no restart while busy
      add_access(OP_TICK,  16'h0000, 8'h00);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         write_cart_type(cart_settings[phase]);
         for (int n = 0; n < PHASE_ITEMS; n++)
            add_random_access();
         wait_drained();
      end

      repeat (6) @(posedge clock);
      if (mismatches == 0 && expected_routes.size() == 0)
         $display("PASS bus_decoder_bank_switch_oam_dma_unit");
      else
         $display("FAIL bus_decoder_bank_switch_oam_dma_unit");
      $finish;
   end

endmodule

// File: filelist.f
design/bdbs_pkg.sv
design/bdbs_decode.sv
design/bdbs_route.sv
design/bus_decoder_bank_switch_oam_dma_unit.sv
bench/bus_decoder_bank_switch_oam_dma_unit_tb.sv
